// ===== rtl/jse_pkg.sv =====
// Package for the JSON string escaper: payload structs, character constants
// and the functions that map one raw byte to its escape run.
// No dependencies.
`timescale 1ns / 1ps

package jse_pkg;

    localparam int RUN_MAX   = 6;
    localparam int IDX_W     = $clog2(RUN_MAX);

    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] HIGH_START = 8'h80;

    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_RETURN    = 8'h0D;
    localparam logic [7:0] CHAR_BKSP      = 8'h08;
    localparam logic [7:0] CHAR_FORMFEED  = 8'h0C;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
    localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
    localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
    localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
    localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
    localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
    localparam logic [7:0] NO_SHORT_CODE  = 8'h00;

    localparam logic [IDX_W-1:0] LEN_PLAIN   = IDX_W'(1);
    localparam logic [IDX_W-1:0] LEN_SHORT   = IDX_W'(2);
    localparam logic [IDX_W-1:0] LEN_UNICODE = IDX_W'(6);

    localparam logic [IDX_W-1:0] POS_SLASH   = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_CODE    = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_ZERO_HI = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_ZERO_LO = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_HEX_HI  = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_HEX_LO  = IDX_W'(5);

    typedef logic [IDX_W-1:0] run_idx_t;

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       string_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] escaped_byte;
        logic       run_last;
        logic       string_done;
    } out_item_t;

    // Letter of the two-byte escape, or NO_SHORT_CODE if the byte has none.
    function automatic logic [7:0] short_code(input logic [7:0] c);
        logic [7:0] code;
        begin
            case (c)
                CHAR_QUOTE:     code = CHAR_QUOTE;
                CHAR_BACKSLASH: code = CHAR_BACKSLASH;
                CHAR_NEWLINE:   code = CHAR_LOWER_N;
                CHAR_TAB:       code = CHAR_LOWER_T;
                CHAR_RETURN:    code = CHAR_LOWER_R;
                CHAR_BKSP:      code = CHAR_LOWER_B;
                CHAR_FORMFEED:  code = CHAR_LOWER_F;
                default:        code = NO_SHORT_CODE;
            endcase
            return code;
        end
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        begin
            if (nib < 4'd10)
                return CHAR_ZERO + {4'd0, nib};
            else
                return CHAR_LOWER_A + {4'd0, nib} - 8'd10;
        end
    endfunction

    function automatic run_idx_t run_length(input logic [7:0] c);
        begin
            if (short_code(c) != NO_SHORT_CODE)
                return LEN_SHORT;
            else if (c < CTRL_LIMIT || c >= HIGH_START)
                return LEN_UNICODE;
            else
                return LEN_PLAIN;
        end
    endfunction

    // Byte at position idx of the escape run of c.
    function automatic logic [7:0] run_byte(input logic [7:0] c, input run_idx_t idx);
        logic [7:0] code;
        logic [7:0] b;
        begin
            code = short_code(c);
            case (idx)
                POS_SLASH:   b = (run_length(c) == LEN_PLAIN) ? c : CHAR_BACKSLASH;
                POS_CODE:    b = (code != NO_SHORT_CODE) ? code : CHAR_LOWER_U;
                POS_ZERO_HI: b = CHAR_ZERO;
                POS_ZERO_LO: b = CHAR_ZERO;
                POS_HEX_HI:  b = hex_digit(c[7:4]);
                POS_HEX_LO:  b = hex_digit(c[3:0]);
                default:     b = CHAR_ZERO;
            endcase
            return b;
        end
    endfunction

endpackage

// ===== rtl/jse_in_if.sv =====
// Valid/ready channel that carries raw string bytes into the escaper.
// Depends on jse_pkg for the payload struct.
`timescale 1ns / 1ps

interface jse_in_if;
    logic               valid;
    logic               ready;
    jse_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/jse_out_if.sv =====
// Valid/ready channel that carries escaped output bytes.
// Depends on jse_pkg for the payload struct.
`timescale 1ns / 1ps

interface jse_out_if;
    logic               valid;
    logic               ready;
    jse_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/json_string_escaper.sv =====
// Top level of the JSON string escaper: item register, escape lookup and
// output register. Depends on jse_pkg, jse_in_if and jse_out_if.
`timescale 1ns / 1ps

// Each raw byte is held in an item register and expanded one output byte per
// cycle, while the output is not stalled, into a single output register. A
// byte from 0x20 to 0x7F other than a quote or backslash passes unchanged, so
// plain text streams at one byte per cycle while the output is not stalled; a
// quote, backslash or named control character becomes a two-byte run and any
// other byte below 0x20 or at 0x80 and above a six-byte run. The next raw
// byte is taken in the same cycle that the last byte of the current run
// moves into the output register.
module json_string_escaper (
    input  logic      clk,
    input  logic      rst_n,
    jse_in_if.sink    raw,
    jse_out_if.source escaped
);
    import jse_pkg::*;

    logic       cur_valid_reg;
    logic [7:0] cur_byte_reg;
    logic       cur_end_reg;
    run_idx_t   idx_reg;
    run_idx_t   idx_next;

    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_data_reg;

    run_idx_t   run_len;
    logic       at_last;
    logic       advance;
    logic       take_in;

    assign run_len = run_length(cur_byte_reg);
    assign at_last = (idx_reg == run_len - IDX_W'(1));
    assign advance = cur_valid_reg && (!out_valid_reg || escaped.ready);
    assign take_in = raw.valid && raw.ready;

    assign raw.ready     = !cur_valid_reg || (advance && at_last);
    assign escaped.valid = out_valid_reg;
    assign escaped.data  = out_data_reg;

    always_comb
    begin
        idx_next = idx_reg;
        if (take_in)
            idx_next = '0;
        else if (advance && !at_last)
            idx_next = idx_reg + IDX_W'(1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (escaped.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (take_in)
                cur_valid_reg <= 1'b1;
            else if (advance && at_last)
                cur_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            cur_byte_reg <= raw.data.raw_byte;
            cur_end_reg  <= raw.data.string_end;
        end
        if (advance)
        begin
            out_data_reg.escaped_byte <= run_byte(cur_byte_reg, idx_reg);
            out_data_reg.run_last     <= at_last;
            out_data_reg.string_done  <= at_last && cur_end_reg;
        end
    end

    // The run position never passes the end of the current run.
    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (idx_reg < run_len))
        else $error("run index beyond run length");

    // The end of the string is only ever marked on the closing byte of a run.
    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        escaped.valid && escaped.data.string_done |-> escaped.data.run_last)
        else $error("string_done without run_last");

    // An accepted byte is held for expansion in the next cycle.
    a_take_holds: assert property (@(posedge clk) disable iff (!rst_n)
        take_in |=> cur_valid_reg)
        else $error("accepted byte not held");

    // When a byte that does not close its run is accepted, the run is still in progress.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        escaped.valid && escaped.ready && !escaped.data.run_last |-> cur_valid_reg)
        else $error("run ended early");

    // A new byte is never taken while a run still has bytes left to issue.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && !at_last |-> !raw.ready)
        else $error("input taken in the middle of a run");

endmodule
